// ===== sv/free_block_bitmap_allocator_defines.svh =====
// Assertion macros for the bitmap allocator.
// Both forms sample on clk; the first is disabled while rst_n is low.
`ifndef FREE_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define FREE_BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
`define FBBA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FBBA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FBBA_ASSERT(lbl, prop, msg)
`define FBBA_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== sv/fbba_pkg.sv =====
`timescale 1ns / 1ps
package fbba_pkg;

    localparam int IDX_W  = 12;
    localparam int CFG_W  = 13;
    localparam int BASE_W = 14;

    localparam logic [CFG_W-1:0] TOTAL_RESET = 13'd4096;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_FREE  = 2'd1,
        FUNC_TEST  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_RANGE     = 2'd2,
        ST_DOUBLE    = 2'd3
    } status_t;

endpackage

// ===== sv/free_block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
// Channel   Handshake           Payload
// input     in_valid/in_stall   func, index
// output    out_valid/out_stall result_index, bit_value, status
// config    cfg_valid/cfg_ready total_bits
//
// After reset a clearing pass sets every map word to all ones, one word per cycle,
// with in_stall high meanwhile; the map holds MAP_WORDS words (128 at the default size).
// Allocate reads one map word per cycle through the single read port of the map memory.
// Free and test pass through read, check (where free writes the word back) and response states.
// One request is in flight at a time; a finished result waits in the output register
// while out_stall is high, and the next request is taken once it has been placed there.
module free_block_bitmap_allocator
    import fbba_pkg::*;
#(
    parameter int MAX_BLOCKS = 4096,
    parameter int WORD_WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       func,
    input  logic [IDX_W-1:0] index,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [IDX_W-1:0] result_index,
    output logic             bit_value,
    output logic [1:0]       status,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] total_bits
);

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_WIDTH - 1) / WORD_WIDTH;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

    logic [CFG_W-1:0]      total_reg;
    logic [CFG_W-1:0]      lim;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            total_reg <= total_bits;
        end
    end

    // clamp the configured total to the map capacity
    assign lim = (32'(total_reg) > 32'(MAX_BLOCKS)) ? CFG_W'(MAX_BLOCKS) : total_reg;

    fbba_map_ram #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W),
        .DATA_W (WORD_WIDTH)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fbba_ctrl #(
        .WORD_WIDTH (WORD_WIDTH),
        .MAP_WORDS  (MAP_WORDS),
        .ADDR_W     (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .index        (index),
        .lim          (lim),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_index (result_index),
        .bit_value    (bit_value),
        .status       (status),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

endmodule

// ===== sv/fbba_map_ram.sv =====
`timescale 1ns / 1ps
module fbba_map_ram #(
    parameter int DEPTH  = 128,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/fbba_pick.sv =====
`timescale 1ns / 1ps
module fbba_pick
    import fbba_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int BIT_W      = 5
) (
    input  logic [WORD_WIDTH-1:0] data,
    input  logic [BASE_W-1:0]     base,
    input  logic [CFG_W-1:0]      lim,
    output logic                  hit,
    output logic [BIT_W-1:0]      pos
);

    logic [BASE_W-1:0]     lim_ext;
    logic [BASE_W-1:0]     span;
    logic [WORD_WIDTH-1:0] avail;

    assign lim_ext = BASE_W'(lim);
    // number of block indices from this word's base up to the limit
    assign span    = (lim_ext > base) ? (lim_ext - base) : '0;

    always_comb
    begin
        for (int b = 0; b < WORD_WIDTH; b++)
        begin
            avail[b] = data[b] && (BASE_W'(b) < span);
        end
    end

    always_comb
    begin
        pos = '0;
        for (int b = WORD_WIDTH - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                pos = BIT_W'(b);
            end
        end
    end

    assign hit = |avail;

endmodule

// ===== sv/fbba_ctrl.sv =====
`timescale 1ns / 1ps
`include "free_block_bitmap_allocator_defines.svh"
module fbba_ctrl
    import fbba_pkg::*;
#(
    parameter int WORD_WIDTH = 32,
    parameter int MAP_WORDS  = 128,
    parameter int ADDR_W     = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            func,
    input  logic [IDX_W-1:0]      index,
    input  logic [CFG_W-1:0]      lim,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [IDX_W-1:0]      result_index,
    output logic                  bit_value,
    output logic [1:0]            status,
    output logic                  mem_we,
    output logic [ADDR_W-1:0]     mem_waddr,
    output logic [WORD_WIDTH-1:0] mem_wdata,
    output logic                  mem_re,
    output logic [ADDR_W-1:0]     mem_raddr,
    input  logic [WORD_WIDTH-1:0] mem_rdata
);

    localparam int BIT_W   = $clog2(WORD_WIDTH);
    localparam int CNT_W   = $clog2(MAP_WORDS + 1);
    localparam int DIV_SH  = IDX_W + BIT_W;
    localparam int DIV_MUL = ((1 << DIV_SH) + WORD_WIDTH - 1) / WORD_WIDTH;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SCAN,
        S_RD,
        S_CHK,
        S_RESP
    } state_t;

    state_t             state_reg,    state_next;
    logic [IDX_W-1:0]   idx_reg,      idx_next;
    logic               free_op_reg,  free_op_next;
    logic [ADDR_W-1:0]  word_reg,     word_next;
    logic [BIT_W-1:0]   pos_reg,      pos_next;
    logic [CNT_W-1:0]   rd_word_reg,  rd_word_next;
    logic [BASE_W-1:0]  rd_base_reg,  rd_base_next;
    logic [ADDR_W-1:0]  chk_word_reg, chk_word_next;
    logic [BASE_W-1:0]  chk_base_reg, chk_base_next;
    logic               pend_reg,     pend_next;
    logic [IDX_W-1:0]   res_idx_reg,  res_idx_next;
    logic               res_bit_reg,  res_bit_next;
    status_t            res_st_reg,   res_st_next;
    logic               out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]   out_idx_reg,  out_idx_next;
    logic               out_bit_reg,  out_bit_next;
    status_t            out_st_reg,   out_st_next;

    logic               hit;
    logic [BIT_W-1:0]   hit_pos;
    logic               issue;
    logic               out_load;
    logic [31:0]        quot_prod;
    logic [31:0]        pos_diff;
    logic               cur_bit;

    fbba_pick #(
        .WORD_WIDTH (WORD_WIDTH),
        .BIT_W      (BIT_W)
    ) u_pick (
        .data (mem_rdata),
        .base (chk_base_reg),
        .lim  (lim),
        .hit  (hit),
        .pos  (hit_pos)
    );

    // word of the requested index by reciprocal multiply
    assign quot_prod = 32'(index) * 32'(DIV_MUL);
    assign pos_diff  = 32'(idx_reg) - 32'(word_reg) * 32'(WORD_WIDTH);

    assign issue   = (rd_word_reg < CNT_W'(MAP_WORDS)) && (rd_base_reg < BASE_W'(lim));
    assign cur_bit = mem_rdata[pos_reg];

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        free_op_next   = free_op_reg;
        word_next      = word_reg;
        pos_next       = pos_reg;
        rd_word_next   = rd_word_reg;
        rd_base_next   = rd_base_reg;
        chk_word_next  = chk_word_reg;
        chk_base_next  = chk_base_reg;
        pend_next      = pend_reg;
        res_idx_next   = res_idx_reg;
        res_bit_next   = res_bit_reg;
        res_st_next    = res_st_reg;
        out_idx_next   = out_idx_reg;
        out_bit_next   = out_bit_reg;
        out_st_next    = out_st_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_load       = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = chk_word_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = word_reg;

        case (state_reg)
            S_CLR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = rd_word_reg[ADDR_W-1:0];
                mem_wdata    = '1;
                rd_word_next = rd_word_reg + CNT_W'(1);
                if (rd_word_reg == CNT_W'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next     = index;
                    free_op_next = (func == FUNC_FREE);
                    word_next    = ADDR_W'(quot_prod >> DIV_SH);
                    res_idx_next = '0;
                    res_bit_next = 1'b0;
                    res_st_next  = ST_OK;
                    rd_word_next = '0;
                    rd_base_next = '0;
                    pend_next    = 1'b0;
                    if (func == FUNC_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else if (func == FUNC_FREE || func == FUNC_TEST)
                    begin
                        if (BASE_W'(index) >= BASE_W'(lim))
                        begin
                            res_st_next = ST_RANGE;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end

            S_SCAN:
            begin
                if (pend_reg && hit)
                begin
                    // claim the lowest free bit and write the word back
                    mem_we       = 1'b1;
                    mem_waddr    = chk_word_reg;
                    mem_wdata    = mem_rdata & ~(WORD_WIDTH'(1) << hit_pos);
                    res_idx_next = IDX_W'(chk_base_reg + BASE_W'(hit_pos));
                    pend_next    = 1'b0;
                    state_next   = S_RESP;
                end
                else if (issue)
                begin
                    mem_re        = 1'b1;
                    mem_raddr     = rd_word_reg[ADDR_W-1:0];
                    chk_word_next = rd_word_reg[ADDR_W-1:0];
                    chk_base_next = rd_base_reg;
                    rd_word_next  = rd_word_reg + CNT_W'(1);
                    rd_base_next  = rd_base_reg + BASE_W'(WORD_WIDTH);
                    pend_next     = 1'b1;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    res_st_next = ST_NONE_FREE;
                    state_next  = S_RESP;
                end
            end

            S_RD:
            begin
                mem_re     = 1'b1;
                mem_raddr  = word_reg;
                pos_next   = BIT_W'(pos_diff);
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (free_op_reg)
                begin
                    if (cur_bit)
                    begin
                        res_st_next = ST_DOUBLE;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = word_reg;
                        mem_wdata = mem_rdata | (WORD_WIDTH'(1) << pos_reg);
                    end
                end
                else
                begin
                    res_bit_next = cur_bit;
                end
                state_next = S_RESP;
            end

            S_RESP:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_bit_next   = res_bit_reg;
                    out_st_next    = res_st_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            idx_reg       <= '0;
            free_op_reg   <= 1'b0;
            word_reg      <= '0;
            pos_reg       <= '0;
            rd_word_reg   <= '0;
            rd_base_reg   <= '0;
            chk_word_reg  <= '0;
            chk_base_reg  <= '0;
            pend_reg      <= 1'b0;
            res_idx_reg   <= '0;
            res_bit_reg   <= 1'b0;
            res_st_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
            out_idx_reg   <= '0;
            out_bit_reg   <= 1'b0;
            out_st_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            free_op_reg   <= free_op_next;
            word_reg      <= word_next;
            pos_reg       <= pos_next;
            rd_word_reg   <= rd_word_next;
            rd_base_reg   <= rd_base_next;
            chk_word_reg  <= chk_word_next;
            chk_base_reg  <= chk_base_next;
            pend_reg      <= pend_next;
            res_idx_reg   <= res_idx_next;
            res_bit_reg   <= res_bit_next;
            res_st_reg    <= res_st_next;
            out_valid_reg <= out_valid_next;
            out_idx_reg   <= out_idx_next;
            out_bit_reg   <= out_bit_next;
            out_st_reg    <= out_st_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_index = out_idx_reg;
    assign bit_value    = out_bit_reg;
    assign status       = out_st_reg;

    `FBBA_ASSERT(a_no_rw_clash,
        !(mem_we && mem_re && mem_waddr == mem_raddr), "map read and write collide")
    `FBBA_ASSERT(a_we_states,
        mem_we |-> (state_reg == S_CLR || state_reg == S_SCAN || state_reg == S_CHK),
        "map write outside clear or update")
    `FBBA_ASSERT(a_load_shows, out_load |=> out_valid_reg, "loaded result not presented")
    `FBBA_ASSERT(a_bit_ok,
        (out_valid_reg && out_bit_reg) |-> (out_st_reg == ST_OK),
        "test bit set with error status")
    `FBBA_ASSERT_RST(a_rst_quiet, !rst_n |-> !out_valid_reg, "result valid during reset")

endmodule

// ===== tb/sv/tb_free_block_bitmap_allocator.sv =====
`timescale 1ns / 1ps
module tb_free_block_bitmap_allocator;
    import fbba_pkg::*;

    localparam int NUM_BLOCKS = 4096;
    localparam logic [1:0] FUNC_NOP = 2'd3;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_CYCLES = 160;
    localparam int PHASE_ITEMS = 50;
    localparam int NUM_PHASES = 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             bitv;
        logic [1:0]       st;
    } alloc_resp_t;

    typedef struct packed {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_val;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        bit               typed;
        alloc_resp_t      resp;
    } plan_row_t;

    localparam alloc_resp_t NO_RESP = '0;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [1:0]       func;
    logic [IDX_W-1:0] index;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [IDX_W-1:0] result_index;
    logic             bit_value;
    logic [1:0]       status;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] total_bits;

    // Shadow of the allocator: one bit per block, 1 = free
    bit [NUM_BLOCKS-1:0] blk_free;
    logic [CFG_W-1:0]    blocks_managed;
    alloc_resp_t         resp_expect_q [$];
    int                  mismatches = 0;
    int                  quiet_cycles = 0;
    int                  burst_left = 0;
    int                  stall_run = 0;

    // Directed walk: reset state, extremes of the total, every operation and error code
    plan_row_t plan [25] = '{
        '{1'b0, 13'd0,    FUNC_TEST,  12'd0,    1'b1, '{12'd0, 1'b1, ST_OK}},
        '{1'b0, 13'd0,    FUNC_TEST,  12'd4095, 1'b1, '{12'd0, 1'b1, ST_OK}},
        '{1'b0, 13'd0,    FUNC_ALLOC, 12'd0,    1'b1, '{12'd0, 1'b0, ST_OK}},
        '{1'b0, 13'd0,    FUNC_ALLOC, 12'd4095, 1'b1, '{12'd1, 1'b0, ST_OK}},
        '{1'b0, 13'd0,    FUNC_TEST,  12'd0,    1'b1, '{12'd0, 1'b0, ST_OK}},
        '{1'b0, 13'd0,    FUNC_FREE,  12'd0,    1'b1, '{12'd0, 1'b0, ST_OK}},
        '{1'b0, 13'd0,    FUNC_FREE,  12'd0,    1'b1, '{12'd0, 1'b0, ST_DOUBLE}},
        '{1'b0, 13'd0,    FUNC_NOP,   12'd4095, 1'b1, '{12'd0, 1'b0, ST_OK}},
        '{1'b0, 13'd0,    FUNC_FREE,  12'd4095, 1'b1, '{12'd0, 1'b0, ST_DOUBLE}},
        '{1'b1, 13'd1,    FUNC_ALLOC, 12'd0,    1'b0, NO_RESP},
        '{1'b0, 13'd0,    FUNC_ALLOC, 12'd0,    1'b1, '{12'd0, 1'b0, ST_OK}},
        '{1'b0, 13'd0,    FUNC_ALLOC, 12'd0,    1'b1, '{12'd0, 1'b0, ST_NONE_FREE}},
        '{1'b0, 13'd0,    FUNC_TEST,  12'd1,    1'b1, '{12'd0, 1'b0, ST_RANGE}},
        '{1'b0, 13'd0,    FUNC_FREE,  12'd4095, 1'b1, '{12'd0, 1'b0, ST_RANGE}},
        '{1'b0, 13'd0,    FUNC_FREE,  12'd0,    1'b1, '{12'd0, 1'b0, ST_OK}},
        '{1'b1, 13'd0,    FUNC_ALLOC, 12'd0,    1'b0, NO_RESP},
        '{1'b0, 13'd0,    FUNC_ALLOC, 12'd0,    1'b1, '{12'd0, 1'b0, ST_NONE_FREE}},
        '{1'b0, 13'd0,    FUNC_TEST,  12'd0,    1'b1, '{12'd0, 1'b0, ST_RANGE}},
        '{1'b0, 13'd0,    FUNC_FREE,  12'd0,    1'b1, '{12'd0, 1'b0, ST_RANGE}},
        '{1'b1, 13'd8191, FUNC_ALLOC, 12'd0,    1'b0, NO_RESP},
        '{1'b0, 13'd0,    FUNC_TEST,  12'd4095, 1'b1, '{12'd0, 1'b1, ST_OK}},
        '{1'b0, 13'd0,    FUNC_ALLOC, 12'd0,    1'b0, NO_RESP},
        '{1'b0, 13'd0,    FUNC_FREE,  12'd1,    1'b1, '{12'd0, 1'b0, ST_OK}},
        '{1'b0, 13'd0,    FUNC_ALLOC, 12'd0,    1'b0, NO_RESP},
        '{1'b0, 13'd0,    FUNC_TEST,  12'd2048, 1'b0, NO_RESP}
    };

    free_block_bitmap_allocator uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .index        (index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_index (result_index),
        .bit_value    (bit_value),
        .status       (status),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .total_bits   (total_bits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int active_limit();
        if (blocks_managed > CFG_W'(NUM_BLOCKS))
            return NUM_BLOCKS;
        return int'(blocks_managed);
    endfunction

    // Apply one request to the shadow map and return the result it must give
    function automatic alloc_resp_t predict_alloc_op(logic [1:0] op, logic [IDX_W-1:0] idx);
        alloc_resp_t r;
        int lim;
        bit found;
        r = NO_RESP;
        r.st = ST_OK;
        lim = active_limit();
        found = 1'b0;
        case (op)
            FUNC_ALLOC:
            begin
                for (int k = 0; k < lim && !found; k++)
                begin
                    if (blk_free[k])
                    begin
                        blk_free[k] = 1'b0;
                        r.idx = IDX_W'(k);
                        found = 1'b1;
                    end
                end
                if (!found)
                    r.st = ST_NONE_FREE;
            end
            FUNC_FREE:
            begin
                if (int'(idx) >= lim)
                    r.st = ST_RANGE;
                else if (blk_free[idx])
                    r.st = ST_DOUBLE;
                else
                    blk_free[idx] = 1'b1;
            end
            FUNC_TEST:
            begin
                if (int'(idx) >= lim)
                    r.st = ST_RANGE;
                else
                    r.bitv = blk_free[idx];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // Hold valid through a burst, then drop it for a short gap
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(60, 150);
            else
                burst_left = $urandom_range(1, 20);
        end
    endtask

    task automatic issue_request(logic [1:0] op, logic [IDX_W-1:0] idx, bit typed,
                                 alloc_resp_t typed_resp);
        alloc_resp_t r;
        in_valid <= 1'b1;
        func     <= op;
        index    <= idx;
        do @(posedge clk); while (in_stall !== 1'b0);
        r = predict_alloc_op(op, idx);
        resp_expect_q.push_back(typed ? typed_resp : r);
        pace();
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        do @(posedge clk); while (resp_expect_q.size() != 0);
    endtask

    task automatic write_total(logic [CFG_W-1:0] val);
        wait_results_done();
        cfg_valid  <= 1'b1;
        total_bits <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        blocks_managed = val;
        cfg_valid <= 1'b0;
    endtask

    // Bias free and test indices toward the low blocks, where allocations land
    task automatic random_request(int alloc_pct, output bit was_nop);
        int lim;
        int roll;
        logic [1:0] op;
        logic [IDX_W-1:0] idx;
        lim = active_limit();
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct)
            op = FUNC_ALLOC;
        else if (roll < alloc_pct + (100 - alloc_pct) * 3 / 5)
            op = FUNC_FREE;
        else if (roll < 96)
            op = FUNC_TEST;
        else
            op = FUNC_NOP;
        idx = IDX_W'($urandom);
        roll = $urandom_range(0, 99);
        if (lim > 0 && roll < 55)
            idx = IDX_W'($urandom_range(0, (lim < 48 ? lim : 48) - 1));
        else if (lim > 0 && roll < 85)
            idx = IDX_W'($urandom_range(0, lim - 1));
        was_nop = (op == FUNC_NOP);
        issue_request(op, idx, 1'b0, NO_RESP);
    endtask

    // Receiver: short stalls, short open runs, and now and then a long open stretch
    always @(posedge clk)
    begin
        int roll;
        if (stall_run > 0)
            stall_run--;
        else
        begin
            roll = $urandom_range(0, 9);
            if (roll < 3)
            begin
                out_stall <= 1'b1;
                stall_run = $urandom_range(0, 7);
            end
            else if (roll == 3)
            begin
                out_stall <= 1'b0;
                stall_run = $urandom_range(40, 150);
            end
            else
            begin
                out_stall <= 1'b0;
                stall_run = $urandom_range(0, 12);
            end
        end
    end

    always @(posedge clk)
    begin
        alloc_resp_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (resp_expect_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: index %0d bit %0d status %0d",
                             result_index, bit_value, status);
            end
            else
            begin
                want = resp_expect_q.pop_front();
                if (result_index !== want.idx || bit_value !== want.bitv
                        || status !== want.st)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: expected index %0d bit %0d status %0d,",
                                  " got index %0d bit %0d status %0d"},
                                 want.idx, want.bitv, want.st,
                                 result_index, bit_value, status);
                end
            end
        end
    end

    // Watchdog: end the run if no transaction completes on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid === 1'b1 && in_stall === 1'b0)
                || (out_valid === 1'b1 && out_stall === 1'b0)
                || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int alloc_pct;
        int served;
        bit was_nop;
        logic [CFG_W-1:0] phase_total;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        func       <= FUNC_ALLOC;
        index      <= '0;
        cfg_valid  <= 1'b0;
        total_bits <= TOTAL_RESET;
        blk_free = '1;
        blocks_managed = TOTAL_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_total(plan[i].cfg_val);
            else
                issue_request(plan[i].op, plan[i].idx, plan[i].typed, plan[i].resp);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: phase_total = 13'd4096;
                1: phase_total = 13'd1;
                2: phase_total = 13'd33;
                3: phase_total = 13'd8191;
                4: phase_total = 13'd0;
                5: phase_total = 13'd64;
                6: phase_total = 13'd4095;
                7: phase_total = 13'd5;
                8: phase_total = CFG_W'($urandom_range(1, 200));
                default: phase_total = CFG_W'($urandom_range(0, 8191));
            endcase
            write_total(phase_total);
            alloc_pct = $urandom_range(30, 70);
            served = 0;
            while (served < PHASE_ITEMS)
            begin
                random_request(alloc_pct, was_nop);
                if (!was_nop)
                    served++;
                if ($urandom_range(0, 49) == 0)
                    wait_results_done();
            end
        end

        wait_results_done();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && resp_expect_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
